// File: rtl/char_lcd_parallel_controller_macros.svh
// Assertion helpers used by the checker file.
`ifndef CHAR_LCD_PARALLEL_CONTROLLER_MACROS_SVH
`define CHAR_LCD_PARALLEL_CONTROLLER_MACROS_SVH

// Same-cycle implication, off during reset.
`define CLCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define CLCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clcd_pkg.sv
package clcd_pkg;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_INIT   = 3'd1,
        KIND_LOAD   = 3'd2,
        KIND_WRITE  = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_CURSOR = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_CURSOR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_PARAM = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_RAISE = 2'd0,
        PH_LOWER = 2'd1,
        PH_WAIT  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_FUNCTION = 8'h38;
    localparam logic [7:0] CMD_DISPLAY  = 8'h0E;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] ROW_FIRST    = 8'h80;
    localparam logic [7:0] ROW_SECOND   = 8'hC0;
    localparam logic [2:0] INIT_LAST    = 3'd4;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] byte_index;
        logic [7:0] msg_byte;
        logic [7:0] msg_length;
        logic [7:0] row_address;
        logic [7:0] column;
    } t_lcd_in;

    typedef struct packed {
        t_status    status;
        logic       reg_select;
        logic       read_write;
        logic       enable_pin;
        logic [7:0] data_bus;
        logic       ready_res;
    } t_lcd_out;

    // Power-on command order, indexed by init step minus one.
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = CMD_FUNCTION;
            2'd1:    cmd = CMD_DISPLAY;
            2'd2:    cmd = CMD_CLEAR;
            default: cmd = CMD_ENTRY;
        endcase
        return cmd;
    endfunction

endpackage

// File: rtl/clcd_msg_ram.sv
module clcd_msg_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-after-write bypass: a load to the address being read wins.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr_data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: rtl/clcd_seq.sv
module clcd_seq #(
    parameter int MSG_DEPTH = 64,
    parameter int COLUMNS   = 16,
    parameter int AW        = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  clcd_pkg::t_lcd_in         i_req,
    input  logic [7:0]                i_char,
    output logic [AW-1:0]             o_rd_addr,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [7:0]                o_wr_data,
    output clcd_pkg::t_lcd_out        o_res
);

    localparam int CW = $clog2(MSG_DEPTH + 1);

    logic                r_oper, n_oper;
    logic [2:0]          r_step, n_step;
    clcd_pkg::t_req      r_pend, n_pend;
    clcd_pkg::t_phase    r_phase, n_phase;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_len, n_len;
    logic [7:0]          r_cursor, n_cursor;
    logic                r_rs, n_rs;
    logic                r_en, n_en;
    logic [7:0]          r_data, n_data;

    logic                w_strobe;
    logic                w_done;
    logic                w_srs;
    logic [7:0]          w_sbyte;
    logic                w_busy;
    logic [CW:0]         w_pos_inc;
    logic [8:0]          w_idx;
    clcd_pkg::t_status   w_status;

    // What a tick would send from the current state.
    always_comb begin
        w_strobe = 1'b0;
        w_srs    = 1'b0;
        w_sbyte  = 8'h00;
        if (!r_oper) begin
            w_strobe = (r_step != 3'd0) && (r_step <= clcd_pkg::INIT_LAST);
            w_sbyte  = clcd_pkg::init_cmd(r_step[1:0] - 2'd1);
        end else begin
            case (r_pend)
                clcd_pkg::REQ_WRITE: begin
                    w_strobe = 1'b1;
                    w_srs    = 1'b1;
                    w_sbyte  = i_char;
                end
                clcd_pkg::REQ_CLEAR: begin
                    w_strobe = 1'b1;
                    w_sbyte  = clcd_pkg::CMD_CLEAR;
                end
                clcd_pkg::REQ_CURSOR: begin
                    w_strobe = 1'b1;
                    w_sbyte  = r_cursor;
                end
                default: w_strobe = 1'b0;
            endcase
        end
    end

    assign w_done    = w_strobe && (r_phase == clcd_pkg::PH_DONE);
    assign w_busy    = !r_oper || (r_pend != clcd_pkg::REQ_NONE);
    assign w_pos_inc = (CW+1)'(r_pos) + (CW+1)'(1);
    assign w_idx     = {3'b000, i_req.byte_index};

    always_comb begin
        n_oper    = r_oper;
        n_step    = r_step;
        n_pend    = r_pend;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len     = r_len;
        n_cursor  = r_cursor;
        n_rs      = r_rs;
        n_en      = r_en;
        n_data    = r_data;
        w_status  = clcd_pkg::ST_OK;
        o_wr_en   = 1'b0;
        if (i_step) begin
            case (i_req.kind)
                clcd_pkg::KIND_TICK: begin
                    if (w_strobe) begin
                        case (r_phase)
                            clcd_pkg::PH_RAISE: begin
                                n_rs    = w_srs;
                                n_data  = w_sbyte;
                                n_en    = 1'b1;
                                n_phase = clcd_pkg::PH_LOWER;
                            end
                            clcd_pkg::PH_LOWER: begin
                                n_en    = 1'b0;
                                n_phase = clcd_pkg::PH_WAIT;
                            end
                            clcd_pkg::PH_WAIT: n_phase = clcd_pkg::PH_DONE;
                            default:           n_phase = clcd_pkg::PH_RAISE;
                        endcase
                        if (w_done) begin
                            if (!r_oper) begin
                                if (r_step == clcd_pkg::INIT_LAST) begin
                                    n_oper = 1'b1;
                                    n_step = 3'd0;
                                    n_pend = clcd_pkg::REQ_NONE;
                                end else begin
                                    n_step = r_step + 3'd1;
                                end
                            end else if (r_pend == clcd_pkg::REQ_WRITE) begin
                                if (w_pos_inc >= (CW+1)'(r_len)) begin
                                    n_pos  = '0;
                                    n_pend = clcd_pkg::REQ_NONE;
                                end else begin
                                    n_pos = w_pos_inc[CW-1:0];
                                end
                            end else begin
                                n_pend = clcd_pkg::REQ_NONE;
                            end
                        end
                    end else if (!r_oper) begin
                        // power-on tick
                        n_step = 3'd1;
                    end
                end
                clcd_pkg::KIND_INIT: begin
                    n_oper  = 1'b0;
                    n_step  = 3'd0;
                    n_pend  = clcd_pkg::REQ_NONE;
                    n_phase = clcd_pkg::PH_RAISE;
                    n_pos   = '0;
                    n_en    = 1'b0;
                end
                clcd_pkg::KIND_LOAD: begin
                    o_wr_en = (w_idx < 9'(MSG_DEPTH));
                end
                clcd_pkg::KIND_WRITE: begin
                    if (w_busy) begin
                        w_status = clcd_pkg::ST_BUSY;
                    end else if ({1'b0, i_req.msg_length} > 9'(MSG_DEPTH)) begin
                        w_status = clcd_pkg::ST_PARAM;
                    end else if (i_req.msg_length != 8'd0) begin
                        n_len  = CW'({1'b0, i_req.msg_length});
                        n_pos  = '0;
                        n_pend = clcd_pkg::REQ_WRITE;
                    end
                end
                clcd_pkg::KIND_CLEAR: begin
                    if (w_busy) begin
                        w_status = clcd_pkg::ST_BUSY;
                    end else begin
                        n_pend = clcd_pkg::REQ_CLEAR;
                    end
                end
                clcd_pkg::KIND_CURSOR: begin
                    if (w_busy) begin
                        w_status = clcd_pkg::ST_BUSY;
                    end else if ((i_req.row_address != clcd_pkg::ROW_FIRST) &&
                                 (i_req.row_address != clcd_pkg::ROW_SECOND)) begin
                        w_status = clcd_pkg::ST_PARAM;
                    end else if ({1'b0, i_req.column} > 9'(COLUMNS)) begin
                        w_status = clcd_pkg::ST_PARAM;
                    end else begin
                        n_cursor = i_req.row_address + i_req.column;
                        n_pend   = clcd_pkg::REQ_CURSOR;
                    end
                end
                default: w_status = clcd_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oper   <= 1'b0;
            r_step   <= 3'd0;
            r_pend   <= clcd_pkg::REQ_NONE;
            r_phase  <= clcd_pkg::PH_RAISE;
            r_pos    <= '0;
            r_len    <= '0;
            r_cursor <= 8'h00;
            r_rs     <= 1'b0;
            r_en     <= 1'b0;
            r_data   <= 8'h00;
        end else begin
            r_oper   <= n_oper;
            r_step   <= n_step;
            r_pend   <= n_pend;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_cursor <= n_cursor;
            r_rs     <= n_rs;
            r_en     <= n_en;
            r_data   <= n_data;
        end
    end

    // RAM is read at the next character position so the byte is ready next cycle.
    assign o_rd_addr = n_pos[AW-1:0];
    assign o_wr_addr = w_idx[AW-1:0];
    assign o_wr_data = i_req.msg_byte;

    assign o_res.status     = w_status;
    assign o_res.reg_select = n_rs;
    assign o_res.read_write = 1'b0;
    assign o_res.enable_pin = n_en;
    assign o_res.data_bus   = n_data;
    assign o_res.ready_res  = n_oper && (n_pend == clcd_pkg::REQ_NONE);

endmodule

// File: rtl/char_lcd_parallel_controller.sv
// Character LCD controller for an 8-bit parallel bus (HD44780 style). Every
// request on the input channel is a tick, an init, a message byte load, or a
// write/clear/cursor command, and each one yields exactly one response that
// reports the status and the RS/RW/EN/DB pin levels after that request. The
// block takes one request per clock while the output register is free or
// being drained; a request passes through the input register, then the
// sequencer logic into the output register, where its response is held.
// While a response waits to be taken, the input register still accepts one
// more request, then input ready stays low until the response drains. The
// message buffer is a RAM with a registered read port that is pre-read at the
// next character position, with a bypass for a load to that same address.
module char_lcd_parallel_controller #(
    parameter int MSG_DEPTH = 64,
    parameter int COLUMNS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clcd_pkg::t_lcd_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clcd_pkg::t_lcd_out o_out
);

    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

    // input register
    logic               r_in_valid;
    clcd_pkg::t_lcd_in  r_in;
    // output register
    logic               r_out_valid;
    clcd_pkg::t_lcd_out r_out;

    logic               w_step;
    logic               w_in_take;
    clcd_pkg::t_lcd_out w_res;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [7:0]         w_wr_data;
    logic [7:0]         w_char;

    // A registered request is processed when the output register is free
    // or is being drained this cycle.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
    end

    clcd_seq #(
        .MSG_DEPTH (MSG_DEPTH),
        .COLUMNS   (COLUMNS),
        .AW        (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_req     (r_in),
        .i_char    (w_char),
        .o_rd_addr (w_rd_addr),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_res     (w_res)
    );

    clcd_msg_ram #(
        .DEPTH (MSG_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/clcd_checker.sv
`include "char_lcd_parallel_controller_macros.svh"

module clcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input clcd_pkg::t_lcd_out o_out
);

    `CLCD_ASSERT_NOW(a_rw_low, i_clk, i_rst_n, o_out_valid, o_out.read_write == 1'b0, "RW pin not low")

    `CLCD_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n, o_out_valid && (o_out.status == clcd_pkg::ST_BUSY), o_out.ready_res == 1'b0, "refused request but ready")

    `CLCD_ASSERT_NOW(a_ready_en_low, i_clk, i_rst_n, o_out_valid && o_out.ready_res, o_out.enable_pin == 1'b0, "EN high while ready")

    `CLCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled response changed")

endmodule

bind char_lcd_parallel_controller clcd_checker u_clcd_checker (.*);
